>>> rtl/assert_macros.svh
// Assertion macros used by the top RTL file of the key matrix scanner.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is disabled while reset is high.
`define KMS_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define KMS_ASSERT_ALL(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/kms_pkg.sv
// Types and constants of the key matrix scanner.
`default_nettype none

package kms_pkg;

  localparam int CODE_W      = 8;
  localparam int LEVEL_W     = 18;
  localparam int INDEX_W     = 8;
  localparam int REQ_W       = 2;
  localparam int SLOT_FIELDS = 6;
  localparam int SLOT_W      = 3;
  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = CODE_W * (SLOT_FIELDS + 1);

  localparam logic [REQ_W-1:0] REQ_SCAN   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REPORT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_MAP    = 2'd2;

  localparam logic [4:0]        MOD_PREFIX    = 5'b11100;
  localparam logic [CODE_W-1:0] ROLLOVER_CODE = 8'h01;

endpackage

`default_nettype wire

>>> rtl/kms_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module kms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/key_matrix_scan_hid_report.sv
// Key matrix scanner that keeps the pressed-key map and builds HID boot reports.
//
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tuser: req_type; tdata: column_levels, map_index, map_code
// m_*       out  m_tvalid/m_tready  tuser: report_ready; tdata: modifiers, key_one..key_six
//
// A scan item reads and then writes the pressed-map RAM (states IDLE, SCAN); a keymap write
// is done in IDLE; a report request with no change goes from IDLE to DONE, and one after a
// change walks every keymap entry (WALK, DRAIN, DONE), as the one keymap RAM read port is
// used once per entry. After reset a clearing pass zeroes both RAMs; no item is taken then.
// A finished report waits in the output register; further scan and keymap items are taken
// meanwhile, and a new report request waits in its last state until the output is free.
`default_nettype none

module key_matrix_scan_hid_report
  import kms_pkg::*;
#(
  parameter int ROWS      = 8,
  parameter int COLS      = 18,
  parameter int KEY_SLOTS = 6
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // Bits from 0: column_levels[17:0], map_index[25:18], map_code[33:26], zero pad.
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  // Bits from 0: req_type[1:0].
  input  wire logic [REQ_W-1:0]      s_tuser,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // Bits from 0: modifiers[7:0], key_one[15:8], key_two, key_three, key_four,
  // key_five, key_six[55:48].
  output logic [OUT_DATA_W-1:0]      m_tdata,
  // Bits from 0: report_ready.
  output logic [0:0]                 m_tuser
);

`include "assert_macros.svh"

  localparam int MAP_SIZE = ROWS * COLS;
  localparam int MAP_AW   = MAP_SIZE > 1 ? $clog2(MAP_SIZE) : 1;
  localparam int ROW_AW   = ROWS > 1 ? $clog2(ROWS) : 1;
  localparam int COL_AW   = COLS > 1 ? $clog2(COLS) : 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CLEAR = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_WALK  = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  // Input fields.
  logic [REQ_W-1:0]   req_type;
  logic [LEVEL_W-1:0] column_levels;
  logic [INDEX_W-1:0] map_index;
  logic [CODE_W-1:0]  map_code;

  assign req_type      = s_tuser;
  assign column_levels = s_tdata[LEVEL_W-1:0];
  assign map_index     = s_tdata[LEVEL_W +: INDEX_W];
  assign map_code      = s_tdata[LEVEL_W + INDEX_W +: CODE_W];

  // Control state.
  logic [2:0]        state;
  logic [MAP_AW-1:0] idx;
  logic [ROW_AW-1:0] row;
  logic [COL_AW-1:0] col;
  logic [ROW_AW-1:0] scan_row;
  logic              changed;
  logic              rd_valid;

  // Datapath registers.
  logic [LEVEL_W-1:0] levels;
  logic [COL_AW-1:0]  rd_col;
  logic [CODE_W-1:0]  mods;
  logic [SLOT_W-1:0]  used;
  logic               overflow;
  logic [CODE_W-1:0]  slots [SLOT_FIELDS];

  // RAM ports.
  logic              km_we;
  logic [MAP_AW-1:0] km_waddr;
  logic [CODE_W-1:0] km_wdata;
  logic [CODE_W-1:0] km_rdata;
  logic              pm_we;
  logic [ROW_AW-1:0] pm_waddr;
  logic [COLS-1:0]   pm_wdata;
  logic [ROW_AW-1:0] pm_raddr;
  logic [COLS-1:0]   pm_rdata;

  logic                  in_accept;
  logic                  load_out;
  logic                  idx_last;
  logic [31:0]           levels_wide;
  logic [COLS-1:0]       now_pressed;
  logic                  key_hit;
  logic [OUT_DATA_W-1:0] payload;

  assign s_tready  = (state == ST_IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign load_out  = (state == ST_DONE) && (!m_tvalid || m_tready);
  assign idx_last  = (idx == MAP_AW'(MAP_SIZE - 1));

  // Column levels are active low; columns past the input field read as pressed.
  assign levels_wide = 32'(levels);
  assign now_pressed = ~levels_wide[COLS-1:0];

  assign key_hit = rd_valid && pm_rdata[rd_col];

  // Report payload: slots past KEY_SLOTS stay zero, rollover fills the used slots.
  always_comb begin
    payload[CODE_W-1:0] = mods;
    for (int k = 0; k < SLOT_FIELDS; k++) begin
      payload[CODE_W*(k+1) +: CODE_W] = (overflow && (k < KEY_SLOTS)) ? ROLLOVER_CODE
                                                                      : slots[k];
    end
  end

  // RAM access steering.
  always_comb begin
    km_we    = 1'b0;
    km_waddr = MAP_AW'(map_index);
    km_wdata = map_code;
    pm_we    = 1'b0;
    pm_waddr = scan_row;
    pm_wdata = now_pressed;
    pm_raddr = (state == ST_WALK) ? row : scan_row;
    case (state)
      ST_CLEAR: begin
        km_we    = 1'b1;
        km_waddr = idx;
        km_wdata = '0;
        pm_we    = (32'(idx) < ROWS);
        pm_waddr = ROW_AW'(idx);
        pm_wdata = '0;
      end
      ST_IDLE: begin
        km_we = in_accept && (req_type == REQ_MAP) && (32'(map_index) < MAP_SIZE);
      end
      ST_SCAN: begin
        pm_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  kms_ram #(.WIDTH(CODE_W), .DEPTH(MAP_SIZE)) u_key_map (
    .clk   (clk),
    .we    (km_we),
    .waddr (km_waddr),
    .wdata (km_wdata),
    .raddr (idx),
    .rdata (km_rdata)
  );

  kms_ram #(.WIDTH(COLS), .DEPTH(ROWS)) u_pressed_map (
    .clk   (clk),
    .we    (pm_we),
    .waddr (pm_waddr),
    .wdata (pm_wdata),
    .raddr (pm_raddr),
    .rdata (pm_rdata)
  );

  // Control sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      idx      <= '0;
      row      <= '0;
      col      <= '0;
      scan_row <= '0;
      changed  <= 1'b0;
      rd_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      rd_valid <= (state == ST_WALK);
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          if (idx_last) begin
            idx   <= '0;
            state <= ST_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_IDLE: begin
          if (in_accept) begin
            case (req_type)
              REQ_SCAN: begin
                state <= ST_SCAN;
              end
              REQ_REPORT: begin
                idx   <= '0;
                row   <= '0;
                col   <= '0;
                state <= changed ? ST_WALK : ST_DONE;
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (pm_rdata != now_pressed) begin
            changed <= 1'b1;
          end
          scan_row <= (scan_row == ROW_AW'(ROWS - 1)) ? '0 : scan_row + 1'b1;
          state    <= ST_IDLE;
        end
        ST_WALK: begin
          idx <= idx + 1'b1;
          if (col == COL_AW'(COLS - 1)) begin
            col <= '0;
            row <= row + 1'b1;
          end else begin
            col <= col + 1'b1;
          end
          if (idx_last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (load_out) begin
            changed  <= 1'b0;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Report builder and payload registers.
  always_ff @(posedge clk) begin
    rd_col <= col;
    if (in_accept && (req_type == REQ_SCAN)) begin
      levels <= column_levels;
    end
    if (in_accept && (req_type == REQ_REPORT)) begin
      mods     <= '0;
      used     <= '0;
      overflow <= 1'b0;
      for (int k = 0; k < SLOT_FIELDS; k++) begin
        slots[k] <= '0;
      end
    end else if (key_hit) begin
      if (km_rdata[CODE_W-1:3] == MOD_PREFIX) begin
        mods[km_rdata[2:0]] <= 1'b1;
      end else if (km_rdata != '0) begin
        if (!overflow && (used < SLOT_W'(KEY_SLOTS))) begin
          slots[used] <= km_rdata;
          used        <= used + 1'b1;
        end else begin
          overflow <= 1'b1;
        end
      end
    end
    if (load_out) begin
      m_tdata <= payload;
      m_tuser <= changed;
    end
  end

  `KMS_ASSERT_RST(a_slots_bounded, rd_valid |-> (used <= SLOT_W'(KEY_SLOTS)), "slot count past KEY_SLOTS")
  `KMS_ASSERT_RST(a_report_clears, load_out |=> !changed, "changed flag kept after report")
  `KMS_ASSERT_RST(a_row_advances,
    (state == ST_SCAN) |=> ((scan_row != $past(scan_row)) || (ROWS == 1)),
    "scan did not advance the row")
  `KMS_ASSERT_RST(a_empty_report, (m_tvalid && (m_tuser == 1'b0)) |-> (m_tdata == '0),
    "unchanged report carries data")
  `KMS_ASSERT_RST(a_out_source, $rose(m_tvalid) |-> $past(state == ST_DONE),
    "output raised outside the report finish")

endmodule

`default_nettype wire
